[sv/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg: shared widths, register indexes and helpers
// Fixed-point formats and saturating arithmetic for the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int ERR_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int TI_W      = 16;
  localparam int MUL_A_W   = ERR_W + 1;
  localparam int PROD_W    = MUL_A_W + GAIN_W;
  localparam int QUOT_W    = ACC_W + FRAC_BITS;
  localparam int MUL_CNT_W = $clog2(GAIN_W);
  localparam int DIV_CNT_W = $clog2(QUOT_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd4;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

[sv/pidc_in_if.sv]
// ----------------------------------------------------------------------------
// pidc_in_if: input item channel
// Valid/ready channel carrying the operation and the error sample.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  import pidc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [ERR_W-1:0] error_in;

  modport source(output valid, op, error_in, input ready);
  modport sink(input valid, op, error_in, output ready);
endinterface

[sv/pidc_out_if.sv]
// ----------------------------------------------------------------------------
// pidc_out_if: result item channel
// Valid/ready channel carrying the clamped drive and the three terms.
// ----------------------------------------------------------------------------
interface pidc_out_if;
  import pidc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] drive;
  logic signed [ACC_W-1:0] p_term;
  logic signed [ACC_W-1:0] i_term;
  logic signed [ACC_W-1:0] d_term;

  modport source(output valid, drive, p_term, i_term, d_term, input ready);
  modport sink(input valid, drive, p_term, i_term, d_term, output ready);
endinterface

[sv/pidc_mul.sv]
// ----------------------------------------------------------------------------
// pidc_mul: bit-serial signed multiplier
// Shift-add over the gain bits, one bit per cycle, sign bit subtracted.
// ----------------------------------------------------------------------------
module pidc_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pidc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [pidc_pkg::GAIN_W-1:0]   b_i,
  output logic                                 busy_o,
  output logic signed [pidc_pkg::PROD_W-1:0]   prod_o
);
  import pidc_pkg::*;

  localparam logic [MUL_CNT_W-1:0] LastStep = MUL_CNT_W'(GAIN_W - 1);

  logic signed [PROD_W-1:0] acc_q, acc_d, mcand_q, term;
  logic [GAIN_W-1:0]        mplier_q;
  logic [MUL_CNT_W-1:0]     cnt_q;
  logic                     busy_q;

  assign term  = mplier_q[0] ? mcand_q : '0;
  assign acc_d = (cnt_q == LastStep) ? acc_q - term : acc_q + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= PROD_W'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;
endmodule

[sv/pidc_div.sv]
// ----------------------------------------------------------------------------
// pidc_div: restoring divider for the integral term
// Divides |sum| scaled by the fraction bits by ti, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pidc_pkg::ACC_W-1:0]   dividend_i,
  input  logic [pidc_pkg::TI_W-1:0]           divisor_i,
  output logic                                busy_o,
  output logic                                neg_o,
  output logic [pidc_pkg::QUOT_W-1:0]         quot_o
);
  import pidc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(QUOT_W - 1);

  logic [QUOT_W-1:0]    dvd_q;
  logic [TI_W-1:0]      rem_q;
  logic [TI_W:0]        trial, diff;
  logic [ACC_W-1:0]     mag;
  logic                 ge, neg_q, busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  assign mag   = dividend_i[ACC_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial = {rem_q, dvd_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      neg_q <= dividend_i[ACC_W-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[QUOT_W-2:0], ge};
      rem_q <= ge ? diff[TI_W-1:0] : trial[TI_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign neg_o  = neg_q;
  assign quot_o = dvd_q;
endmodule

[sv/pid_controller_clamped.sv]
// ----------------------------------------------------------------------------
// pid_controller_clamped: discrete PID step with output clamp
// A step item runs the two 16-step serial multipliers and, when ti is not zero,
// the 40-step serial divider; the result waits until every started unit is done.
// The input takes no new item until the previous step has handed its result to
// the output register; a clear item gives no result.
// Reset: gains, ti and clamps take their defaults; integral sum and previous
// error are cleared; no result is pending.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pidc_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  pidc_in_if.sink                              in_i,
  pidc_out_if.source                           out_o
);
  import pidc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_RUN    = 7'b0000100,
    ST_ITERM  = 7'b0001000,
    ST_ADD_PI = 7'b0010000,
    ST_ADD_D  = 7'b0100000,
    ST_CLAMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [GAIN_W-1:0] kp_q, kd_q;
  logic [TI_W-1:0]          ti_q;
  logic signed [ACC_W-1:0]  out_min_q, out_max_q;

  logic signed [ACC_W-1:0]  integral_sum_q;
  logic signed [ERR_W-1:0]  last_error_q, e_q;
  logic signed [MUL_A_W-1:0] diff_d, diff_q;

  logic                     in_acc, unit_start, div_start;
  logic                     mul_p_busy, mul_d_busy, div_busy, div_neg;
  logic signed [PROD_W-1:0] prod_p, prod_d, shift_p, shift_d;
  logic [QUOT_W-1:0]        quot;
  logic signed [ACC_W-1:0]  i_sat, drive_d;
  logic signed [ACC_W-1:0]  p_q, i_q, d_q, sum_pi_q, total_q;
  logic signed [ACC_W-1:0]  out_drive_q, out_p_q, out_i_q, out_d_q;
  logic                     out_vld_q, out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign unit_start = (state_q == ST_LOAD);
  assign div_start  = unit_start && (ti_q != '0);
  assign diff_d     = {in_i.error_in[ERR_W-1], in_i.error_in}
                    - {last_error_q[ERR_W-1], last_error_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= GAIN_W'(256);
      ti_q      <= '0;
      kd_q      <= '0;
      out_min_q <= ACC_MIN;
      out_max_q <= ACC_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KP:      kp_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_TI:      ti_q      <= cfg_data_i[TI_W-1:0];
        CFG_KD:      kd_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_OUT_MIN: out_min_q <= cfg_data_i[ACC_W-1:0];
        CFG_OUT_MAX: out_max_q <= cfg_data_i[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && (in_i.op == OP_STEP)) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_RUN;
      ST_RUN:    if (!mul_p_busy && !mul_d_busy && !div_busy) state_d = ST_ITERM;
      ST_ITERM:  state_d = ST_ADD_PI;
      ST_ADD_PI: state_d = ST_ADD_D;
      ST_ADD_D:  state_d = ST_CLAMP;
      ST_CLAMP:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      integral_sum_q <= '0;
      last_error_q   <= '0;
      out_vld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_i.op == OP_CLEAR) begin
          integral_sum_q <= '0;
          last_error_q   <= '0;
        end else begin
          last_error_q <= in_i.error_in;
          if (ti_q != '0) begin
            integral_sum_q <= sat_add(integral_sum_q,
                                      {{(ACC_W-ERR_W){in_i.error_in[ERR_W-1]}}, in_i.error_in});
          end
        end
      end
      if (state_q == ST_CLAMP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  pidc_mul u_mul_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .a_i     ({e_q[ERR_W-1], e_q}),
    .b_i     (kp_q),
    .busy_o  (mul_p_busy),
    .prod_o  (prod_p)
  );

  pidc_mul u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .a_i     (diff_q),
    .b_i     (kd_q),
    .busy_o  (mul_d_busy),
    .prod_o  (prod_d)
  );

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (integral_sum_q),
    .divisor_i  (ti_q),
    .busy_o     (div_busy),
    .neg_o      (div_neg),
    .quot_o     (quot)
  );

  assign shift_p = prod_p >>> FRAC_BITS;
  assign shift_d = prod_d >>> FRAC_BITS;

  always_comb begin
    if (div_neg) begin
      if ((|quot[QUOT_W-1:ACC_W]) || (quot[ACC_W-1] && (|quot[ACC_W-2:0]))) begin
        i_sat = ACC_MIN;
      end else begin
        i_sat = ~quot[ACC_W-1:0] + 1'b1;
      end
    end else if (|quot[QUOT_W-1:ACC_W-1]) begin
      i_sat = ACC_MAX;
    end else begin
      i_sat = quot[ACC_W-1:0];
    end
  end

  always_comb begin
    if (total_q < out_min_q) begin
      drive_d = out_min_q;
    end else if (total_q > out_max_q) begin
      drive_d = out_max_q;
    end else begin
      drive_d = total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q    <= in_i.error_in;
      diff_q <= diff_d;
    end
    if (state_q == ST_ITERM) begin
      p_q <= shift_p[ACC_W-1:0];
      d_q <= shift_d[ACC_W-1:0];
      i_q <= (ti_q != '0) ? i_sat : '0;
    end
    if (state_q == ST_ADD_PI) begin
      sum_pi_q <= sat_add(p_q, i_q);
    end
    if (state_q == ST_ADD_D) begin
      total_q <= sat_add(sum_pi_q, d_q);
    end
    if (state_q == ST_CLAMP && out_free) begin
      out_drive_q <= drive_d;
      out_p_q     <= p_q;
      out_i_q     <= i_q;
      out_d_q     <= d_q;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.drive  = out_drive_q;
  assign out_o.p_term = out_p_q;
  assign out_o.i_term = out_i_q;
  assign out_o.d_term = out_d_q;

`ifndef SYNTHESIS
  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.op == OP_STEP)) |=> (state_q == ST_LOAD))
    else $error("step item did not start the units");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.op == OP_CLEAR)) |=> (integral_sum_q == '0 && last_error_q == '0))
    else $error("clear item left state behind");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!mul_p_busy && !mul_d_busy && !div_busy))
    else $error("ready while an arithmetic unit is busy");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_CLAMP))
    else $error("result raised outside the clamp stage");

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |-> (!mul_p_busy && !mul_d_busy && !div_busy))
    else $error("unit restarted while busy");
`endif
endmodule

[dv/tb_pid_controller_clamped.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped: self-checking bench for the clamped PID step
// Drives step and clear items through the valid/ready input channel, keeps an
// independent fixed-point PID predictor with its own copy of the gains, the
// clamps, the integral sum and the previous error, and compares every result
// field by field. Covers reset defaults, gain and clamp extremes, inverted
// clamps, writes to unused register indexes, integral saturation and long
// random runs under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped;
  import pidc_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SAT_STEPS     = 300;
  localparam int SEGMENTS      = 5;
  localparam int SEGMENT_ITEMS = 90;
  localparam int GAIN_PAD_W    = CFG_DAT_W - GAIN_W;
  localparam int TI_PAD_W      = CFG_DAT_W - TI_W;

  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);
  localparam logic [TI_W-1:0]          TI_MAX   = '1;
  localparam logic [TI_W-1:0]          TI_OFF   = '0;

  typedef struct {
    logic signed [ACC_W-1:0] drive;
    logic signed [ACC_W-1:0] p_term;
    logic signed [ACC_W-1:0] i_term;
    logic signed [ACC_W-1:0] d_term;
  } pid_terms_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  pidc_in_if  in_ch();
  pidc_out_if out_ch();

  pid_controller_clamped uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic signed [GAIN_W-1:0] kp_q;
  logic signed [GAIN_W-1:0] kd_q;
  logic [TI_W-1:0]          ti_q;
  logic signed [ACC_W-1:0]  out_min_q;
  logic signed [ACC_W-1:0]  out_max_q;
  logic signed [ACC_W-1:0]  integral_q;
  logic signed [ERR_W-1:0]  last_err_q;

  pid_terms_t pending_terms_q[$];
  int fail_cnt       = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [ACC_W-1:0] saturate_acc(input logic signed [63:0] x);
    if (x > 64'(ACC_MAX)) return ACC_MAX;
    if (x < 64'(ACC_MIN)) return ACC_MIN;
    return x[ACC_W-1:0];
  endfunction

  function automatic void compute_pid_step(input logic signed [ERR_W-1:0] err);
    logic signed [63:0]      prod;
    logic signed [63:0]      quot;
    logic signed [ACC_W-1:0] total;
    pid_terms_t              t;
    prod = 64'(kp_q) * 64'(err);
    t.p_term = saturate_acc(prod >>> FRAC_BITS);
    if (ti_q != TI_OFF) begin
      integral_q = saturate_acc(64'(integral_q) + 64'(err));
      quot = (64'(integral_q) <<< FRAC_BITS) / $signed({{(64-TI_W){1'b0}}, ti_q});
      t.i_term = saturate_acc(quot);
    end else begin
      t.i_term = '0;
    end
    prod = 64'(kd_q) * (64'(err) - 64'(last_err_q));
    t.d_term = saturate_acc(prod >>> FRAC_BITS);
    last_err_q = err;
    total = saturate_acc(64'(t.p_term) + 64'(t.i_term));
    total = saturate_acc(64'(total) + 64'(t.d_term));
    if (total < out_min_q) begin
      t.drive = out_min_q;
    end else if (total > out_max_q) begin
      t.drive = out_max_q;
    end else begin
      t.drive = total;
    end
    pending_terms_q.push_back(t);
  endfunction

  function automatic void check_field(input string field, input logic signed [ACC_W-1:0] exp_v,
                                      input logic signed [ACC_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    pid_terms_t exp_t;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_terms_q.size() == 0) begin
        $error("drive: expected no item, got %0d", out_ch.drive);
        fail_cnt++;
      end else begin
        exp_t = pending_terms_q.pop_front();
        check_field("drive", exp_t.drive, out_ch.drive);
        check_field("p_term", exp_t.p_term, out_ch.p_term);
        check_field("i_term", exp_t.i_term, out_ch.i_term);
        check_field("d_term", exp_t.d_term, out_ch.d_term);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_pid_controller_clamped NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic signed [ERR_W-1:0] err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.error_in <= err;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_CLEAR) begin
      integral_q = '0;
      last_err_q = '0;
    end else begin
      compute_pid_step(err);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_terms_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_KP:      kp_q = data[GAIN_W-1:0];
      CFG_TI:      ti_q = data[TI_W-1:0];
      CFG_KD:      kd_q = data[GAIN_W-1:0];
      CFG_OUT_MIN: out_min_q = data[ACC_W-1:0];
      CFG_OUT_MAX: out_max_q = data[ACC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic signed [GAIN_W-1:0] kp, input logic [TI_W-1:0] ti,
                             input logic signed [GAIN_W-1:0] kd,
                             input logic signed [ACC_W-1:0] lo,
                             input logic signed [ACC_W-1:0] hi);
    settle();
    write_reg(CFG_KP, {GAIN_PAD_W'($urandom), kp});
    write_reg(CFG_TI, {TI_PAD_W'($urandom), ti});
    write_reg(CFG_KD, {GAIN_PAD_W'($urandom), kd});
    write_reg(CFG_OUT_MIN, lo);
    write_reg(CFG_OUT_MAX, hi);
    // unused indexes must leave every register untouched
    for (int k = int'(CFG_OUT_MAX) + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), $urandom());
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
      1:       return GAIN_W'(int'($urandom_range(1023)) - 512);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [TI_W-1:0] pick_ti();
    case ($urandom_range(4))
      0:       return TI_OFF;
      1:       return TI_W'($urandom_range(1, 8));
      2:       return TI_MAX;
      default: return TI_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error();
    case ($urandom_range(6))
      0:       return ERR_MAX;
      1:       return ERR_MIN;
      2:       return ERR_W'(int'($urandom_range(1023)) - 512);
      default: return ERR_W'($urandom);
    endcase
  endfunction

  task automatic pick_clamps(output logic signed [ACC_W-1:0] lo,
                             output logic signed [ACC_W-1:0] hi);
    case ($urandom_range(4))
      0: begin
        lo = ACC_MIN;
        hi = ACC_MAX;
      end
      1: begin
        lo = -$signed(ACC_W'($urandom_range(1 << 20)));
        hi = $signed(ACC_W'($urandom_range(1 << 20)));
      end
      2: begin
        lo = ACC_MAX;
        hi = ACC_MIN;
      end
      default: begin
        lo = $signed(ACC_W'($urandom));
        hi = $signed(ACC_W'($urandom));
      end
    endcase
  endtask

  task automatic test_reset_defaults();
    send_item(OP_CLEAR, ERR_MAX);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, ERR_MAX);
    send_item(OP_STEP, ERR_MIN);
    send_item(OP_STEP, 16'sd1);
    send_item(OP_STEP, -16'sd1);
    send_item(OP_STEP, 16'sh5555);
  endtask

  task automatic test_gain_extremes();
    load_config(GAIN_MAX, TI_MAX, GAIN_MAX, ACC_MIN, ACC_MAX);
    send_item(OP_STEP, ERR_MAX);
    send_item(OP_STEP, ERR_MIN);
    send_item(OP_STEP, ERR_MAX);
    load_config(GAIN_MIN, TI_W'(1), GAIN_MIN, ACC_MIN, ACC_MAX);
    send_item(OP_STEP, ERR_MIN);
    send_item(OP_STEP, ERR_MAX);
    send_item(OP_CLEAR, ERR_MIN);
    send_item(OP_STEP, ERR_MIN);
  endtask

  task automatic test_clamp();
    load_config(GAIN_ONE, TI_OFF, '0, -32'sd100, 32'sd100);
    send_item(OP_STEP, ERR_MAX);
    send_item(OP_STEP, ERR_MIN);
    send_item(OP_STEP, 16'sd100);
    // inverted window: below out_min gives out_min, everything else out_max
    load_config(GAIN_ONE, TI_OFF, '0, 32'sd1000, -32'sd1000);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, ERR_MAX);
    send_item(OP_STEP, ERR_MIN);
  endtask

  task automatic test_integral_saturation();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_config('0, TI_W'(1), '0, ACC_MIN, ACC_MAX);
    send_item(OP_CLEAR, '0);
    repeat (SAT_STEPS) send_item(OP_STEP, ERR_MAX);
    repeat (4) send_item(OP_STEP, ERR_MIN);
  endtask

  task automatic test_random();
    int                      idle_sets[3][2] = '{'{15, 45}, '{45, 15}, '{0, 0}};
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < SEGMENTS; s++) begin
        pick_clamps(lo, hi);
        load_config(pick_gain(), pick_ti(), pick_gain(), lo, hi);
        send_idle_pct  = idle_sets[ph][0];
        recv_stall_pct = idle_sets[ph][1];
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          send_item(($urandom_range(24) == 0) ? OP_CLEAR : OP_STEP, pick_error());
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_KP;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_STEP;
    in_ch.error_in = '0;
    out_ch.ready   = 1'b0;
    kp_q           = GAIN_ONE;
    ti_q           = TI_OFF;
    kd_q           = '0;
    out_min_q      = ACC_MIN;
    out_max_q      = ACC_MAX;
    integral_q     = '0;
    last_err_q     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct  = 15;
    recv_stall_pct = 45;
    test_reset_defaults();
    test_gain_extremes();
    test_clamp();
    test_integral_saturation();
    test_random();
    settle();
    if (fail_cnt == 0) begin
      $display("tb_pid_controller_clamped OK");
    end else begin
      $display("tb_pid_controller_clamped NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pidc_pkg.sv
sv/pidc_in_if.sv
sv/pidc_out_if.sv
sv/pidc_mul.sv
sv/pidc_div.sv
sv/pid_controller_clamped.sv
dv/tb_pid_controller_clamped.sv
